// ===== rtl/occupancy_frontier_detector_core_defines.svh =====
// Assertion macros shared by the frontier detector RTL.
`ifndef OCCUPANCY_FRONTIER_DETECTOR_CORE_DEFINES_SVH
`define OCCUPANCY_FRONTIER_DETECTOR_CORE_DEFINES_SVH

// Check a condition in the same cycle as its trigger.
`define OFD_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a condition in the cycle after its trigger.
`define OFD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ofd_pkg.sv =====
// Shared types, constants and helpers of the occupancy frontier detector.
`timescale 1ns / 1ps
`default_nettype none
package ofd_pkg;

    localparam int CODE_W  = 8;
    localparam int COORD_W = 10;
    localparam int COUNT_W = 4;
    localparam int CFG_W   = 11;
    localparam int CLS_W   = 2;
    localparam int WIN_W   = 9 * CLS_W;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    typedef logic [CLS_W-1:0] t_cls;

    localparam t_cls CLS_OCCUPIED = 2'd0;
    localparam t_cls CLS_FREE     = 2'd1;
    localparam t_cls CLS_UNKNOWN  = 2'd2;

    localparam logic [CODE_W-1:0] CODE_FREE     = 8'd0;
    localparam logic [CODE_W-1:0] CODE_OCCUPIED = 8'd100;

    localparam logic REG_GRID_WIDTH  = 1'b0;
    localparam logic REG_GRID_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0]   CFG_SIZE_RESET = 11'd1024;
    localparam logic [CFG_W-1:0]   CFG_SIZE_MIN   = 11'd3;
    localparam logic [COUNT_W-1:0] COUNT_MAX      = 4'd8;

    function automatic t_cls classify(input logic [CODE_W-1:0] code);
        t_cls c;
        if (code == CODE_FREE) begin
            c = CLS_FREE;
        end else if (code == CODE_OCCUPIED) begin
            c = CLS_OCCUPIED;
        end else begin
            c = CLS_UNKNOWN;
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/ofd_line_store.sv =====
// Line store memory: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module ofd_line_store #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 4
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

// ===== rtl/occupancy_frontier_detector_core.sv =====
// A result word passes the stage 1 registers and then the output registers after its
// cell word is accepted. One cell word per clock while the output register is free; the
// line store read at accept and the window/score stage overlap.
// Reset (synchronous, active low) clears counters, window, best frontier and
// handshake state, and loads both size registers with 1024. The line stores
// are not cleared: rows are written before they are read.
`timescale 1ns / 1ps
`default_nettype none
`include "occupancy_frontier_detector_core_defines.svh"
module occupancy_frontier_detector_core #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    // configuration port
    input  wire logic                                   psel,
    input  wire logic                                   penable,
    input  wire logic                                   pwrite,
    input  wire logic [ofd_pkg::APB_ADDR_W-1:0]         paddr,
    input  wire logic [ofd_pkg::APB_DATA_W-1:0]         pwdata,
    output logic      [ofd_pkg::APB_DATA_W-1:0]         prdata,
    output logic                                        pready,
    // cell input
    input  wire logic                                   i_in_valid,
    output logic                                        o_in_ready,
    input  wire logic signed [ofd_pkg::CODE_W-1:0]      i_cell_code,
    // result output
    output logic                                        o_out_valid,
    input  wire logic                                   i_out_ready,
    output logic      [ofd_pkg::COORD_W-1:0]            o_cell_x,
    output logic      [ofd_pkg::COORD_W-1:0]            o_cell_y,
    output logic                                        o_is_frontier,
    output logic      [ofd_pkg::COUNT_W-1:0]            o_unknown_count,
    output logic      [ofd_pkg::COORD_W-1:0]            o_best_x,
    output logic      [ofd_pkg::COORD_W-1:0]            o_best_y,
    output logic      [ofd_pkg::COUNT_W-1:0]            o_best_count,
    output logic                                        o_found,
    output logic                                        o_last
);

    import ofd_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int WB = $clog2(MAX_WIDTH + 1);
    localparam int HB = $clog2(MAX_HEIGHT + 1);
    localparam int SB = (WB > HB) ? WB : HB;
    localparam int SW = (SB > CFG_W) ? SB : CFG_W;

    localparam logic [SW-1:0] W_MAX  = SW'(MAX_WIDTH);
    localparam logic [SW-1:0] H_MAX  = SW'(MAX_HEIGHT);
    localparam logic [SW-1:0] SZ_MIN = SW'(CFG_SIZE_MIN);

    // ---------------- configuration ----------------
    logic [CFG_W-1:0] r_grid_width;
    logic [CFG_W-1:0] r_grid_height;
    logic             cfg_wr;

    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= CFG_SIZE_RESET;
            r_grid_height <= CFG_SIZE_RESET;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_GRID_WIDTH:  r_grid_width  <= pwdata[CFG_W-1:0];
                REG_GRID_HEIGHT: r_grid_height <= pwdata[CFG_W-1:0];
                default:         r_grid_width  <= r_grid_width;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_GRID_WIDTH:  prdata = APB_DATA_W'(r_grid_width);
            REG_GRID_HEIGHT: prdata = APB_DATA_W'(r_grid_height);
            default:         prdata = '0;
        endcase
    end

    // ---------------- stage 0: counters and line store read ----------------
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [CW-1:0] n_col;
    logic [RW-1:0] n_row;
    logic [SW-1:0] cfg_w, cfg_h, w_sz, h_sz, col_ext, row_ext, col_p1, row_p1;
    logic          col_wrap, row_wrap, s0_int, s0_last;
    logic          in_acc;

    // stage 1 registers
    logic          r_s1_vld;
    t_cls          r_s1_cls;
    logic [CW-1:0] r_s1_col;
    logic [RW-1:0] r_s1_row;
    logic          r_s1_int;
    logic          r_s1_last;
    logic          r_s1_end;
    logic          s1_go;

    assign in_acc = i_in_valid && o_in_ready;

    always_comb begin
        cfg_w = SW'(r_grid_width);
        cfg_h = SW'(r_grid_height);
        if (cfg_w < SZ_MIN) begin
            w_sz = SZ_MIN;
        end else if (cfg_w > W_MAX) begin
            w_sz = W_MAX;
        end else begin
            w_sz = cfg_w;
        end
        if (cfg_h < SZ_MIN) begin
            h_sz = SZ_MIN;
        end else if (cfg_h > H_MAX) begin
            h_sz = H_MAX;
        end else begin
            h_sz = cfg_h;
        end
        col_ext  = SW'(r_col);
        row_ext  = SW'(r_row);
        col_p1   = col_ext + 1'b1;
        row_p1   = row_ext + 1'b1;
        col_wrap = col_p1 >= w_sz;
        row_wrap = row_p1 >= h_sz;
        s0_int   = (col_ext >= SW'(2)) && (row_ext >= SW'(2))
                   && (col_ext < w_sz) && (row_ext < h_sz);
        s0_last  = (col_p1 == w_sz) && (row_p1 == h_sz);
        n_col    = col_wrap ? '0 : col_p1[CW-1:0];
        n_row    = col_wrap ? (row_wrap ? '0 : row_p1[RW-1:0]) : r_row;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_acc) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // line store word: upper row in the high half, middle row in the low half
    logic [2*CLS_W-1:0] ls_rd_data;
    t_cls               up_cls, mid_cls;

    ofd_line_store #(
        .DEPTH (MAX_WIDTH),
        .WIDTH (2 * CLS_W)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_rd_en   (in_acc),
        .i_rd_addr (r_col),
        .o_rd_data (ls_rd_data),
        .i_wr_en   (s1_go),
        .i_wr_addr (r_s1_col),
        .i_wr_data ({mid_cls, r_s1_cls})
    );

    assign up_cls  = ls_rd_data[2*CLS_W-1:CLS_W];
    assign mid_cls = ls_rd_data[CLS_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (in_acc) begin
            r_s1_vld <= 1'b1;
        end else if (s1_go) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_cls  <= classify(i_cell_code);
            r_s1_col  <= r_col;
            r_s1_row  <= r_row;
            r_s1_int  <= s0_int;
            r_s1_last <= s0_last;
            r_s1_end  <= col_wrap && row_wrap;
        end
    end

    // ---------------- stage 1: window, classification, best frontier ----------------
    logic [WIN_W-1:0]   r_win;
    logic [WIN_W-1:0]   n_win;
    logic [COUNT_W-1:0] r_best_score;
    logic [COORD_W-1:0] r_best_x, r_best_y;
    logic [2:0]         four_unk;
    logic [COUNT_W-1:0] unk_cnt;
    logic               s1_fr, s1_take;
    logic [CW-1:0]      cx;
    logic [RW-1:0]      cy;
    logic [CW+COORD_W-1:0] cx_ext;
    logic [RW+COORD_W-1:0] cy_ext;
    logic [COORD_W-1:0] cx10, cy10;
    logic               out_free;

    // output registers
    logic               r_o_vld;
    logic [COORD_W-1:0] r_o_x, r_o_y, r_o_bx, r_o_by;
    logic               r_o_fr, r_o_found, r_o_last;
    logic [COUNT_W-1:0] r_o_cnt, r_o_bcnt;

    // window cell: col 0 newest .. 2 oldest, row 0 top .. 2 bottom
    function automatic logic unk_at(input logic [WIN_W-1:0] win, input int c, input int r);
        t_cls v;
        v = win[(c * 3 + r) * CLS_W +: CLS_W];
        return v == CLS_UNKNOWN;
    endfunction

    assign out_free   = !r_o_vld || i_out_ready;
    assign s1_go      = r_s1_vld && (!r_s1_int || out_free);
    assign o_in_ready = !r_s1_vld || s1_go;

    always_comb begin
        n_win    = {r_win[WIN_W-3*CLS_W-1:0], r_s1_cls, mid_cls, up_cls};
        four_unk = 3'(unk_at(n_win, 1, 0)) + 3'(unk_at(n_win, 1, 2))
                 + 3'(unk_at(n_win, 0, 1)) + 3'(unk_at(n_win, 2, 1));
        unk_cnt  = COUNT_W'(four_unk)
                 + COUNT_W'(unk_at(n_win, 0, 0)) + COUNT_W'(unk_at(n_win, 2, 0))
                 + COUNT_W'(unk_at(n_win, 0, 2)) + COUNT_W'(unk_at(n_win, 2, 2));
        s1_fr    = (n_win[4*CLS_W +: CLS_W] == CLS_FREE) && (four_unk != 3'd0);
        s1_take  = r_s1_int && s1_fr && (unk_cnt > r_best_score);
        cx       = r_s1_col - 1'b1;
        cy       = r_s1_row - 1'b1;
        cx_ext   = {{COORD_W{1'b0}}, cx};
        cy_ext   = {{COORD_W{1'b0}}, cy};
        cx10     = cx_ext[COORD_W-1:0];
        cy10     = cy_ext[COORD_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win        <= '0;
            r_best_score <= '0;
            r_best_x     <= '0;
            r_best_y     <= '0;
        end else if (s1_go) begin
            r_win <= n_win;
            // drop the best frontier once the grid's final cell has passed
            if (r_s1_end) begin
                r_best_score <= '0;
                r_best_x     <= '0;
                r_best_y     <= '0;
            end else if (s1_take) begin
                r_best_score <= unk_cnt;
                r_best_x     <= cx10;
                r_best_y     <= cy10;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (s1_go && r_s1_int) begin
            r_o_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_o_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && r_s1_int) begin
            r_o_x     <= cx10;
            r_o_y     <= cy10;
            r_o_fr    <= s1_fr;
            r_o_cnt   <= unk_cnt;
            r_o_bx    <= s1_take ? cx10 : r_best_x;
            r_o_by    <= s1_take ? cy10 : r_best_y;
            r_o_bcnt  <= s1_take ? unk_cnt : r_best_score;
            r_o_found <= s1_take || (r_best_score != '0);
            r_o_last  <= r_s1_last;
        end
    end

    assign o_out_valid     = r_o_vld;
    assign o_cell_x        = r_o_x;
    assign o_cell_y        = r_o_y;
    assign o_is_frontier   = r_o_fr;
    assign o_unknown_count = r_o_cnt;
    assign o_best_x        = r_o_bx;
    assign o_best_y        = r_o_by;
    assign o_best_count    = r_o_bcnt;
    assign o_found         = r_o_found;
    assign o_last          = r_o_last;

    // ---------------- assertions ----------------
    `OFD_ASSERT_SAME(a_count_range, o_out_valid, o_unknown_count <= COUNT_MAX, "unknown count above eight")
    `OFD_ASSERT_SAME(a_best_covers, o_out_valid && o_is_frontier, o_found && (o_best_count >= o_unknown_count), "frontier word not covered by best")
    `OFD_ASSERT_SAME(a_stall_blocks, r_s1_vld && !s1_go, !o_in_ready, "cell word taken while window stage is held")
    `OFD_ASSERT_NEXT(a_grid_clear, s1_go && r_s1_end, (r_best_score == '0) && (r_best_x == '0), "best frontier not cleared at grid end")

endmodule
`default_nettype wire
